// ----- rtl/core/oled_page_framebuffer_controller_defines.svh -----
// ----------------------------------------------------------------------------
// OLED page framebuffer controller assertion macros
// Shared assertion helpers for the controller; empty bodies when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef OLED_PAGE_FRAMEBUFFER_CONTROLLER_DEFINES_SVH
`define OLED_PAGE_FRAMEBUFFER_CONTROLLER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, disabled while reset is asserted
`define OLEDFB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("oledfb same-cycle check failed");
// next-cycle implication, disabled while reset is asserted
`define OLEDFB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("oledfb next-cycle check failed");
`else
`define OLEDFB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OLEDFB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/oledfb_pkg.sv -----
// ----------------------------------------------------------------------------
// OLED page framebuffer controller package
// Fixed field widths, bus codes, command codes and pipeline types.
// ----------------------------------------------------------------------------
package oledfb_pkg;

	localparam int ADDR_W  = 7;
	localparam int BYTE_W  = 8;
	localparam int PX_W    = 7;
	localparam int PY_W    = 6;
	localparam int COL_W   = 8;
	localparam int PAGE_W  = 4;
	// wide enough for page * width + column with page and column at full field range
	localparam int CALC_W  = 12;

	// control bytes
	localparam logic [BYTE_W-1:0] CTRL_COMMAND = 8'h00;
	localparam logic [BYTE_W-1:0] CTRL_DATA    = 8'h40;

	// single-byte commands
	localparam logic [BYTE_W-1:0] CMD_DISPLAY_OFF = 8'hAE;
	localparam logic [BYTE_W-1:0] CMD_DISPLAY_ON  = 8'hAF;
	localparam logic [BYTE_W-1:0] CMD_NORMAL      = 8'hA6;
	localparam logic [BYTE_W-1:0] CMD_INVERTED    = 8'hA7;
	localparam logic [BYTE_W-1:0] CMD_COL_LO_MIN  = 8'h00;
	localparam logic [BYTE_W-1:0] CMD_COL_LO_MAX  = 8'h0F;
	localparam logic [BYTE_W-1:0] CMD_COL_HI_MIN  = 8'h10;
	localparam logic [BYTE_W-1:0] CMD_COL_HI_MAX  = 8'h1F;

	// transfer mode after the control byte
	typedef enum logic [3:0] {
		MODE_IGNORE = 4'b0001,
		MODE_CMD    = 4'b0010,
		MODE_DATA   = 4'b0100,
		MODE_OTHER  = 4'b1000
	} mode_t;

	// item in flight between the memory read and the output register
	typedef struct packed {
		logic              accepted;
		logic              pix_ok;
		logic [2:0]        bit_sel;
		logic              invert;
		logic              display;
		logic              panel_on;
		logic [COL_W-1:0]  column;
		logic [PAGE_W-1:0] page;
	} s1_t;

endpackage

// ----- rtl/core/oled_page_framebuffer_controller.sv -----
// ----------------------------------------------------------------------------
// OLED page framebuffer controller
// Page-mode monochrome display controller: bus bytes and pixel reads in,
// one status item out for each item in.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_ready    | cmd first_byte bus_address bus_byte
//          |                        | pixel_x pixel_y
//  out     | out_valid / out_ready  | accepted pixel_lit panel_on write_column
//          |                        | write_page
//
//  One item per cycle sustained while the output is taken and no clearing pass
//  runs; each item passes one framebuffer access. The accept edge issues the
//  memory read or write and loads stage one; the output register loads from
//  stage one when it can advance. After reset a clearing pass writes zero to
//  all PANEL_WIDTH*PANEL_PAGES framebuffer bytes (1024 at default), one per
//  cycle; in_ready is low. A stalled output holds its item; in_ready stays high
//  while the stage in front of the output register can still move.
//
`include "oled_page_framebuffer_controller_defines.svh"

module oled_page_framebuffer_controller
	import oledfb_pkg::*;
#(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_PAGES  = 8,
	parameter int PANEL_HEIGHT = 64,
	parameter int DEVICE_ADDR  = 60
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic              first_byte,
	input  logic [ADDR_W-1:0] bus_address,
	input  logic [BYTE_W-1:0] bus_byte,
	input  logic [PX_W-1:0]   pixel_x,
	input  logic [PY_W-1:0]   pixel_y,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              accepted,
	output logic              pixel_lit,
	output logic              panel_on,
	output logic [COL_W-1:0]  write_column,
	output logic [PAGE_W-1:0] write_page
);

	localparam int STORE_SIZE = PANEL_WIDTH * PANEL_PAGES;
	localparam int MEM_AW     = $clog2(STORE_SIZE);

	// framebuffer, one byte per page column
	logic [BYTE_W-1:0] mem [STORE_SIZE];
	logic [BYTE_W-1:0] rd_data_q;

	// control state
	logic              clear_busy_q;
	logic [MEM_AW-1:0] clr_idx_q;
	mode_t             mode_q, mode_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [PAGE_W-1:0] page_q, page_d;
	logic              disp_q, disp_d;
	logic              inv_q, inv_d;

	// pipeline
	logic              s1_valid_q;
	s1_t               s1_q, s1_d;
	logic              s1_adv;
	logic              in_fire;

	// output register
	logic              out_valid_q;
	logic              acc_q, pix_q, pon_q;
	logic [COL_W-1:0]  wcol_q;
	logic [PAGE_W-1:0] wpage_q;

	// memory access
	logic              data_we;
	logic              mem_we;
	logic [MEM_AW-1:0] mem_waddr;
	logic [CALC_W-1:0] wr_sum, rd_sum;
	logic [COL_W:0]    col_inc;
	logic              pix_ok;
	logic              acc_d;
	logic              pixel_bit;

	assign s1_adv   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !clear_busy_q && (!s1_valid_q || s1_adv);
	assign in_fire  = in_valid && in_ready;

	// byte addresses for the write pointer and for the pixel read
	assign wr_sum  = CALC_W'(page_q) * CALC_W'(PANEL_WIDTH) + CALC_W'(col_q);
	assign rd_sum  = CALC_W'(pixel_y[PY_W-1:3]) * CALC_W'(PANEL_WIDTH) + CALC_W'(pixel_x);
	assign col_inc = {1'b0, col_q} + (COL_W+1)'(1);

	// decode the accepted item and work out the next control state
	always_comb begin
		mode_d  = mode_q;
		col_d   = col_q;
		page_d  = page_q;
		disp_d  = disp_q;
		inv_d   = inv_q;
		acc_d   = 1'b0;
		data_we = 1'b0;
		pix_ok  = 1'b0;
		if (in_fire) begin
			if (cmd) begin
				// drop reads outside the panel or the store
				pix_ok = (int'(pixel_x) < PANEL_WIDTH) && (int'(pixel_y) < PANEL_HEIGHT)
					&& (int'(pixel_y[PY_W-1:3]) < PANEL_PAGES)
					&& (int'(rd_sum) < STORE_SIZE);
			end else if (first_byte) begin
				if (bus_address != ADDR_W'(DEVICE_ADDR)) begin
					mode_d = MODE_IGNORE;
				end else begin
					acc_d = 1'b1;
					if (bus_byte == CTRL_COMMAND) begin
						mode_d = MODE_CMD;
					end else if (bus_byte == CTRL_DATA) begin
						mode_d = MODE_DATA;
					end else begin
						mode_d = MODE_OTHER;
					end
				end
			end else if (mode_q != MODE_IGNORE) begin
				acc_d = 1'b1;
				case (mode_q)
					MODE_CMD: begin
						case (bus_byte) inside
							CMD_DISPLAY_OFF: disp_d = 1'b0;
							CMD_DISPLAY_ON:  disp_d = 1'b1;
							CMD_NORMAL:      inv_d  = 1'b0;
							CMD_INVERTED:    inv_d  = 1'b1;
							[CMD_COL_LO_MIN:CMD_COL_LO_MAX]: col_d = {col_q[7:4], bus_byte[3:0]};
							[CMD_COL_HI_MIN:CMD_COL_HI_MAX]: col_d = {bus_byte[3:0], col_q[3:0]};
							default: ;
						endcase
					end
					MODE_DATA: begin
						// hold pointers past the last page or outside the store
						if ((int'(page_q) < PANEL_PAGES) && (int'(wr_sum) < STORE_SIZE)) begin
							data_we = 1'b1;
							if (int'(col_inc) >= PANEL_WIDTH) begin
								col_d  = '0;
								page_d = page_q + PAGE_W'(1);
							end else begin
								col_d = col_inc[COL_W-1:0];
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		s1_d          = s1_q;
		s1_d.accepted = acc_d;
		s1_d.pix_ok   = pix_ok;
		s1_d.bit_sel  = pixel_y[2:0];
		s1_d.invert   = inv_q;
		s1_d.display  = disp_q;
		s1_d.panel_on = disp_d;
		s1_d.column   = col_d;
		s1_d.page     = page_d;
	end

	// clearing pass shares the write port; no item is taken meanwhile
	assign mem_we    = clear_busy_q || data_we;
	assign mem_waddr = clear_busy_q ? clr_idx_q : wr_sum[MEM_AW-1:0];

	// items are one per edge, so a read never meets a write of the same edge
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= clear_busy_q ? '0 : bus_byte;
		end
		if (in_fire && cmd) begin
			rd_data_q <= mem[rd_sum[MEM_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_busy_q <= 1'b1;
			clr_idx_q    <= '0;
		end else if (clear_busy_q) begin
			if (clr_idx_q == MEM_AW'(STORE_SIZE - 1)) begin
				clear_busy_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + MEM_AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IGNORE;
			col_q  <= '0;
			page_q <= '0;
			disp_q <= 1'b1;
			inv_q  <= 1'b0;
		end else begin
			mode_q <= mode_d;
			col_q  <= col_d;
			page_q <= page_d;
			disp_q <= disp_d;
			inv_q  <= inv_d;
		end
	end

	// stage one: waits for the memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			s1_q <= s1_d;
		end
	end

	assign pixel_bit = s1_q.pix_ok
		& ((rd_data_q[s1_q.bit_sel] ^ s1_q.invert) & s1_q.display);

	// output register: load from stage one, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			acc_q   <= s1_q.accepted;
			pix_q   <= pixel_bit;
			pon_q   <= s1_q.panel_on;
			wcol_q  <= s1_q.column;
			wpage_q <= s1_q.page;
		end
	end

	assign out_valid    = out_valid_q;
	assign accepted     = acc_q;
	assign pixel_lit    = pix_q;
	assign panel_on     = pon_q;
	assign write_column = wcol_q;
	assign write_page   = wpage_q;

	`OLEDFB_ASSERT_IMP(a_no_take_in_clear, clk, arst_n, clear_busy_q, !in_ready)
	`OLEDFB_ASSERT_IMP(a_page_in_range, clk, arst_n, 1'b1, int'(page_q) <= PANEL_PAGES)
	`OLEDFB_ASSERT_IMP(a_pixel_needs_panel, clk, arst_n, out_valid_q && pix_q, pon_q)
	`OLEDFB_ASSERT_NXT(a_fire_fills_s1, clk, arst_n, in_fire, s1_valid_q)
	`OLEDFB_ASSERT_IMP(a_full_blocks_in, clk, arst_n, s1_valid_q && out_valid_q && !out_ready, !in_ready)

endmodule

// ----- tb/sv/oledfb_status_checker.sv -----
// ----------------------------------------------------------------------------
// OLED page framebuffer controller status checker
// Watches both channels, keeps a shadow copy of the controller state, predicts
// the status item for every accepted input item and compares it in order.
// ----------------------------------------------------------------------------
module oledfb_status_checker
	import oledfb_pkg::*;
#(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_PAGES  = 8,
	parameter int PANEL_HEIGHT = 64,
	parameter int DEVICE_ADDR  = 60
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              cmd,
	input  logic              first_byte,
	input  logic [ADDR_W-1:0] bus_address,
	input  logic [BYTE_W-1:0] bus_byte,
	input  logic [PX_W-1:0]   pixel_x,
	input  logic [PY_W-1:0]   pixel_y,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic              accepted,
	input  logic              pixel_lit,
	input  logic              panel_on,
	input  logic [COL_W-1:0]  write_column,
	input  logic [PAGE_W-1:0] write_page,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_SIZE = PANEL_WIDTH * PANEL_PAGES;

	typedef struct packed {
		logic              accepted;
		logic              pixel_lit;
		logic              panel_on;
		logic [COL_W-1:0]  write_column;
		logic [PAGE_W-1:0] write_page;
	} status_t;

	status_t           expected_status[$];
	logic [BYTE_W-1:0] shadow_fb [STORE_SIZE];
	logic [COL_W-1:0]  shadow_col;
	logic [PAGE_W-1:0] shadow_page;
	logic              shadow_disp;
	logic              shadow_inv;
	mode_t             shadow_mode;

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	// advance the shadow state by one input item and queue its status
	task automatic predict_status(input logic c, input logic f,
			input logic [ADDR_W-1:0] a, input logic [BYTE_W-1:0] b,
			input logic [PX_W-1:0] x, input logic [PY_W-1:0] y);
		status_t st;
		int      pg;
		int      addr;
		int      nxt;
		st = '0;
		if (c) begin
			pg = int'(y) >> 3;
			addr = pg * PANEL_WIDTH + int'(x);
			if (int'(x) < PANEL_WIDTH && int'(y) < PANEL_HEIGHT && pg < PANEL_PAGES &&
					addr < STORE_SIZE)
				st.pixel_lit = (shadow_fb[addr][y[2:0]] ^ shadow_inv) & shadow_disp;
		end else if (f) begin
			if (int'(a) != DEVICE_ADDR) begin
				shadow_mode = MODE_IGNORE;
			end else begin
				st.accepted = 1'b1;
				if (b == CTRL_COMMAND)
					shadow_mode = MODE_CMD;
				else if (b == CTRL_DATA)
					shadow_mode = MODE_DATA;
				else
					shadow_mode = MODE_OTHER;
			end
		end else if (shadow_mode != MODE_IGNORE) begin
			st.accepted = 1'b1;
			if (shadow_mode == MODE_CMD) begin
				if (b == CMD_DISPLAY_OFF)
					shadow_disp = 1'b0;
				else if (b == CMD_DISPLAY_ON)
					shadow_disp = 1'b1;
				else if (b == CMD_NORMAL)
					shadow_inv = 1'b0;
				else if (b == CMD_INVERTED)
					shadow_inv = 1'b1;
				else if (b <= CMD_COL_LO_MAX)
					shadow_col = {shadow_col[7:4], b[3:0]};
				else if (b <= CMD_COL_HI_MAX)
					shadow_col = {b[3:0], shadow_col[3:0]};
			end else if (shadow_mode == MODE_DATA) begin
				// drop the byte past the last page or outside the store
				addr = int'(shadow_page) * PANEL_WIDTH + int'(shadow_col);
				if (int'(shadow_page) < PANEL_PAGES && addr < STORE_SIZE) begin
					shadow_fb[addr] = b;
					nxt = int'(shadow_col) + 1;
					if (nxt >= PANEL_WIDTH) begin
						shadow_col  = '0;
						shadow_page = shadow_page + 1'b1;
					end else begin
						shadow_col = nxt[COL_W-1:0];
					end
				end
			end
		end
		st.panel_on     = shadow_disp;
		st.write_column = shadow_col;
		st.write_page   = shadow_page;
		expected_status.push_back(st);
	endtask

	always @(posedge clk or negedge arst_n) begin
		status_t want;
		if (!arst_n) begin
			for (int i = 0; i < STORE_SIZE; i++)
				shadow_fb[i] = '0;
			shadow_col  = '0;
			shadow_page = '0;
			shadow_disp = 1'b1;
			shadow_inv  = 1'b0;
			shadow_mode = MODE_IGNORE;
			expected_status.delete();
			errors  = 0;
			pending = 0;
		end else begin
			// check the output first: latency keeps this edge's input out of it
			if (out_valid && out_ready) begin
				if (expected_status.size() == 0) begin
					report("status item with no expectation waiting");
				end else begin
					want = expected_status.pop_front();
					if (accepted !== want.accepted)
						report($sformatf("accepted got %b expected %b",
							accepted, want.accepted));
					if (pixel_lit !== want.pixel_lit)
						report($sformatf("pixel_lit got %b expected %b",
							pixel_lit, want.pixel_lit));
					if (panel_on !== want.panel_on)
						report($sformatf("panel_on got %b expected %b",
							panel_on, want.panel_on));
					if (write_column !== want.write_column)
						report($sformatf("write_column got %0d expected %0d",
							write_column, want.write_column));
					if (write_page !== want.write_page)
						report($sformatf("write_page got %0d expected %0d",
							write_page, want.write_page));
				end
			end
			if (in_valid && in_ready)
				predict_status(cmd, first_byte, bus_address, bus_byte, pixel_x, pixel_y);
			pending = expected_status.size();
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// OLED page framebuffer controller testbench
// Drives directed and random bus transfers and pixel reads with random gaps
// and output stalls; the status checker predicts and compares every item.
// ----------------------------------------------------------------------------
module tb;
	import oledfb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PANEL_WIDTH  = 128;
	localparam int PANEL_PAGES  = 8;
	localparam int PANEL_HEIGHT = 64;
	localparam int DEVICE_ADDR  = 60;
	localparam logic [ADDR_W-1:0] DEV = 7'(DEVICE_ADDR);

	// clearing pass plus worst-case gaps and stalls, taken several times over
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 1790;
	localparam int HOLD_AFTER   = 400;
	localparam int HOLD_CYCLES  = 400;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              cmd = 1'b0;
	logic              first_byte = 1'b0;
	logic [ADDR_W-1:0] bus_address = '0;
	logic [BYTE_W-1:0] bus_byte = '0;
	logic [PX_W-1:0]   pixel_x = '0;
	logic [PY_W-1:0]   pixel_y = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              accepted;
	logic              pixel_lit;
	logic              panel_on;
	logic [COL_W-1:0]  write_column;
	logic [PAGE_W-1:0] write_page;

	int errors;
	int pending;
	int sent_cnt = 0;
	int cycle_cnt = 0;

	oled_page_framebuffer_controller #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_PAGES (PANEL_PAGES),
		.PANEL_HEIGHT(PANEL_HEIGHT),
		.DEVICE_ADDR (DEVICE_ADDR)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.first_byte  (first_byte),
		.bus_address (bus_address),
		.bus_byte    (bus_byte),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.accepted    (accepted),
		.pixel_lit   (pixel_lit),
		.panel_on    (panel_on),
		.write_column(write_column),
		.write_page  (write_page)
	);

	oledfb_status_checker #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_PAGES (PANEL_PAGES),
		.PANEL_HEIGHT(PANEL_HEIGHT),
		.DEVICE_ADDR (DEVICE_ADDR)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.first_byte  (first_byte),
		.bus_address (bus_address),
		.bus_byte    (bus_byte),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.accepted    (accepted),
		.pixel_lit   (pixel_lit),
		.panel_on    (panel_on),
		.write_column(write_column),
		.write_page  (write_page),
		.errors      (errors),
		.pending     (pending)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// end the run if the block hangs
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// mostly back-to-back, sometimes a short gap, rarely a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one item and hold it until the handshake. Valid stays high into
	// the next item when no gap is drawn, so it never drops and rises in one step.
	task automatic send_item(input logic c, input logic f, input logic [ADDR_W-1:0] a,
			input logic [BYTE_W-1:0] b, input logic [PX_W-1:0] x,
			input logic [PY_W-1:0] y);
		int gap;
		gap = pick_gap();
		// keep a calm stretch now and then with no sender idling at all
		if ((sent_cnt / 150) % 5 == 3)
			gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= c;
		first_byte  <= f;
		bus_address <= a;
		bus_byte    <= b;
		pixel_x     <= x;
		pixel_y     <= y;
		do
			@(posedge clk);
		while (!in_ready);
		sent_cnt++;
	endtask

	// bus byte with junk on the pixel fields
	task automatic send_bus(input logic f, input logic [ADDR_W-1:0] a,
			input logic [BYTE_W-1:0] b);
		send_item(1'b0, f, a, b, PX_W'($urandom_range(0, 127)),
			PY_W'($urandom_range(0, 63)));
	endtask

	// continuation byte: its address is not looked at, so randomize it
	task automatic send_next(input logic [BYTE_W-1:0] b);
		send_bus(1'b0, ADDR_W'($urandom_range(0, 127)), b);
	endtask

	// pixel read with junk on the bus fields
	task automatic send_read(input logic [PX_W-1:0] x, input logic [PY_W-1:0] y);
		send_item(1'b1, 1'($urandom_range(0, 1)), ADDR_W'($urandom_range(0, 127)),
			BYTE_W'($urandom_range(0, 255)), x, y);
	endtask

	// Receiver: random stalls, plus one long hold-off counted here so the
	// block fills up and drops in_ready while the sender keeps offering.
	initial begin : receiver
		int  lo;
		int  hi;
		bit  held;
		held = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held && sent_cnt >= HOLD_AFTER) begin
				held = 1'b1;
				out_ready <= 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
			end
			lo = pick_gap();
			if (lo > 0) begin
				out_ready <= 1'b0;
				repeat (lo) @(posedge clk);
			end
			out_ready <= 1'b1;
			hi = $urandom_range(1, 12);
			repeat (hi) @(posedge clk);
		end
	end

	initial begin : stimulus
		int                kind;
		int                len;
		int                r;
		logic [3:0]        nib;
		logic [ADDR_W-1:0] a;
		logic [BYTE_W-1:0] b;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// ---- directed part ----
		// reads of the cleared store at the corners
		send_read(7'd0, 6'd0);
		send_read(7'd127, 6'd63);
		// continuation with no open transfer: not accepted
		send_bus(1'b0, DEV, 8'hFF);
		// wrong address: the transfer is ignored, the continuation too
		send_bus(1'b1, 7'h00, CTRL_DATA);
		send_bus(1'b0, 7'h7F, 8'hAA);
		// every command, with reads in the middle of the transfer
		send_bus(1'b1, DEV, CTRL_COMMAND);
		send_next(CMD_INVERTED);
		send_read(7'd5, 6'd3);
		send_next(CMD_DISPLAY_OFF);
		send_read(7'd5, 6'd3);
		send_next(CMD_DISPLAY_ON);
		send_next(CMD_NORMAL);
		// column beyond the width: high nibble F, low nibble 0
		send_next(CMD_COL_HI_MAX);
		send_next(CMD_COL_LO_MIN);
		send_next(8'hE3);
		// data at column 240 lands in the next page and wraps the pointer
		send_bus(1'b1, DEV, CTRL_DATA);
		send_next(8'hFF);
		send_next(8'h81);
		send_bus(1'b0, 7'h7F, 8'h00);
		send_read(7'd112, 6'd8);
		send_read(7'd0, 6'd15);
		// unknown control byte: accepted, but commands after it do nothing
		send_bus(1'b1, DEV, 8'h80);
		send_next(CMD_DISPLAY_OFF);
		send_read(7'd112, 6'd8);

		// ---- random part ----
		while (sent_cnt < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 28) begin
				// command transfer, mostly meaningful opcodes
				send_bus(1'b1, DEV, CTRL_COMMAND);
				len = $urandom_range(1, 8);
				repeat (len) begin
					r = $urandom_range(0, 99);
					nib = 4'($urandom_range(0, 15));
					if (r < 12)
						b = CMD_DISPLAY_ON;
					else if (r < 17)
						b = CMD_DISPLAY_OFF;
					else if (r < 27)
						b = CMD_NORMAL;
					else if (r < 35)
						b = CMD_INVERTED;
					else if (r < 60)
						b = {CMD_COL_LO_MIN[7:4], nib};
					else if (r < 80) begin
						// keep the column inside the panel most of the time
						if ($urandom_range(0, 99) < 80)
							nib[3] = 1'b0;
						b = {CMD_COL_HI_MIN[7:4], nib};
					end else
						b = BYTE_W'($urandom_range(0, 255));
					send_next(b);
				end
			end else if (kind < 53) begin
				// data transfer, reads mixed in now and then
				send_bus(1'b1, DEV, CTRL_DATA);
				len = $urandom_range(1, 16);
				repeat (len) begin
					if ($urandom_range(0, 99) < 15)
						send_read(PX_W'($urandom_range(0, 127)),
							PY_W'($urandom_range(0, 63)));
					send_next(BYTE_W'($urandom_range(0, 255)));
				end
			end else if (kind < 80) begin
				len = $urandom_range(1, 6);
				repeat (len) send_read(PX_W'($urandom_range(0, 127)),
					PY_W'($urandom_range(0, 63)));
			end else if (kind < 87) begin
				// transfer to another device
				a = ADDR_W'($urandom_range(0, 127));
				if (a == DEV)
					a = a + 1'b1;
				send_bus(1'b1, a, BYTE_W'($urandom_range(0, 255)));
				len = $urandom_range(0, 4);
				repeat (len) send_next(BYTE_W'($urandom_range(0, 255)));
			end else if (kind < 93) begin
				// our address, any control byte
				send_bus(1'b1, DEV, BYTE_W'($urandom_range(0, 255)));
				len = $urandom_range(0, 4);
				repeat (len) send_next(BYTE_W'($urandom_range(0, 255)));
			end else begin
				len = $urandom_range(1, 4);
				repeat (len)
					send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						ADDR_W'($urandom_range(0, 127)), BYTE_W'($urandom_range(0, 255)),
						PX_W'($urandom_range(0, 127)), PY_W'($urandom_range(0, 63)));
			end
		end

		// Walk the pages to the end: column 255 advances a page while the
		// address fits and is dropped on the last page; column 127 then
		// finishes it, and later data falls past the end.
		repeat (9) begin
			send_bus(1'b1, DEV, CTRL_COMMAND);
			send_next(CMD_COL_HI_MAX);
			send_next(CMD_COL_LO_MAX);
			send_bus(1'b1, DEV, CTRL_DATA);
			send_next(BYTE_W'($urandom_range(0, 255)));
		end
		send_bus(1'b1, DEV, CTRL_COMMAND);
		send_next({CMD_COL_HI_MIN[7:4], 4'h7});
		send_next(CMD_COL_LO_MAX);
		send_bus(1'b1, DEV, CTRL_DATA);
		send_next(BYTE_W'($urandom_range(0, 255)));
		send_next(BYTE_W'($urandom_range(0, 255)));
		repeat (6) send_read(PX_W'($urandom_range(0, 127)), PY_W'($urandom_range(0, 63)));

		in_valid <= 1'b0;

		// drain: wait for every status item, then report the result
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		@(negedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
